/* hw/rtl/isotp_tx_segmenter_core_defines.svh */
// Assertion macros shared by the segmenter checkers.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ISOTP_TX_SEGMENTER_CORE_DEFINES_SVH
`define ISOTP_TX_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ISOTP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segmenter check failed (same cycle)");

// Next-cycle implication, disabled during reset
`define ISOTP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segmenter check failed (next cycle)");

`endif

/* hw/rtl/isotp_seg_pkg.sv */
// Shared types and protocol constants for the ISO-TP transmit segmenter.
// No dependencies.
package isotp_seg_pkg;

   // Identifier after reset
   localparam logic [10:0] ID_RESET = 11'h123;

   // Protocol control nibbles (upper half of byte zero)
   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;

   // Longest message that fits a single frame
   localparam logic [11:0] SF_MAX_LEN = 12'd7;
   // Payload bytes carried by a first frame
   localparam logic [11:0] FF_PAYLOAD = 12'd6;
   // Data bytes in a classic CAN frame
   localparam logic [3:0]  CAN_BYTES  = 4'd8;

   // First buffer slot for each frame kind
   localparam logic [3:0] SLOT_SF = 4'd1;
   localparam logic [3:0] SLOT_FF = 4'd2;
   localparam logic [3:0] SLOT_CF = 4'd1;

   // One emitted CAN frame
   typedef struct packed {
      logic             last;
      logic [7:0][7:0]  data;
      logic [3:0]       dlc;
      logic [10:0]      id;
   } frame_type;

endpackage

/* hw/rtl/isotp_tx_segmenter_core.sv */
// ISO-TP transmit segmenter top level: request/response streams, identifier register.
// Depends on isotp_seg_pkg and isotp_seg_engine.
// A closing request byte's frame is registered and appears on rsp in the next cycle.
// Throughput: one request byte per cycle; req_tready drops only while a finished
// frame is held in the response register and rsp_tready is low.
// Reset (synchronous, active high): idle, no frame pending, identifier 0x123.
module isotp_tx_segmenter_core (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], message_length[19:8], zero pad
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // frame_id[10:0], frame_length[14:11],
                                    // byte_zero..byte_seven [22:15]..[78:71], zero pad
   output logic        rsp_tlast    // final_frame
);
   import isotp_seg_pkg::*;

   logic [10:0] ident_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   frame_type   rsp_frame_ff, rsp_frame_in;
   logic        accept;
   logic        emit;
   frame_type   frame;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   isotp_seg_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_tdata[7:0]),
      .message_length   (req_tdata[19:8]),
      .frame_identifier (ident_ff),
      .emit             (emit),
      .frame            (frame)
   );

   // Load a new frame, or drop the held one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_frame_in = rsp_frame_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = frame;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff     <= ID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ident_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Frame payload needs no reset
   always_ff @(posedge clock) begin
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_frame_ff.data, rsp_frame_ff.dlc, rsp_frame_ff.id};
   assign rsp_tlast  = rsp_frame_ff.last;

endmodule

/* hw/rtl/isotp_seg_engine.sv */
// Segmentation engine: message counters, frame buffer and frame assembly.
// Depends on isotp_seg_pkg.
module isotp_seg_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic [11:0]              message_length,
   input  logic [10:0]              frame_identifier,
   output logic                     emit,
   output isotp_seg_pkg::frame_type frame
);
   import isotp_seg_pkg::*;

   logic [11:0]      taken_ff, taken_in;
   logic [11:0]      length_ff, length_in;
   logic [3:0]       seq_ff, seq_in;
   logic [7:0][7:0]  frame_buf_ff, frame_buf_in;
   logic [3:0]       fill_ff, fill_in;

   logic             idle;
   logic [11:0]      len_cur;
   logic [3:0]       fill_cur;
   logic [3:0]       seq_cur;
   logic [7:0][7:0]  work;
   logic [3:0]       fill_new;
   logic [11:0]      taken_new;
   logic             done;

   // Resolve the current message context, opening a new one when idle
   always_comb begin
      idle      = (taken_ff == 12'd0);
      len_cur   = idle ? message_length : length_ff;
      fill_cur  = idle ? ((message_length <= SF_MAX_LEN) ? SLOT_SF : SLOT_FF) : fill_ff;
      seq_cur   = idle ? 4'd1 : seq_ff;
      work      = idle ? '0 : frame_buf_ff;
      work[fill_cur[2:0]] = data_byte;
      fill_new  = fill_cur + 4'd1;
      taken_new = taken_ff + 12'd1;
      done      = (taken_new >= len_cur);
   end

   // Place the byte, decide whether a frame closes and advance state
   always_comb begin
      taken_in     = taken_ff;
      length_in    = length_ff;
      seq_in       = seq_ff;
      frame_buf_in = frame_buf_ff;
      fill_in      = fill_ff;
      emit         = 1'b0;
      frame.id     = frame_identifier;
      frame.dlc    = fill_new;
      frame.data   = work;
      frame.last   = 1'b0;

      if (accept && !(idle && message_length == 12'd0)) begin
         length_in    = len_cur;
         taken_in     = taken_new;
         frame_buf_in = work;
         fill_in      = fill_new;
         seq_in       = seq_cur;

         if (len_cur <= SF_MAX_LEN) begin
            // Single frame closes on the last byte
            if (done) begin
               emit          = 1'b1;
               frame.data[0] = {PCI_SINGLE, len_cur[3:0]};
               frame.last    = 1'b1;
               taken_in      = 12'd0;
               seq_in        = 4'd1;
               frame_buf_in  = '0;
               fill_in       = 4'd0;
            end
         end else if (taken_new == FF_PAYLOAD) begin
            // First frame carries the 12-bit length
            emit          = 1'b1;
            frame.data[0] = {PCI_FIRST, len_cur[11:8]};
            frame.data[1] = len_cur[7:0];
            frame_buf_in  = '0;
            fill_in       = SLOT_CF;
         end else if (taken_new > FF_PAYLOAD && (fill_new >= CAN_BYTES || done)) begin
            // Consecutive frame, full or ending the message
            emit          = 1'b1;
            frame.data[0] = {PCI_CONSEC, seq_cur};
            frame.last    = done;
            seq_in        = seq_cur + 4'd1;
            frame_buf_in  = '0;
            fill_in       = SLOT_CF;
            if (done) begin
               taken_in = 12'd0;
               seq_in   = 4'd1;
               fill_in  = 4'd0;
            end
         end
      end
   end

   // Hold message state
   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff     <= 12'd0;
         length_ff    <= 12'd0;
         seq_ff       <= 4'd1;
         frame_buf_ff <= '0;
         fill_ff      <= 4'd0;
      end else begin
         taken_ff     <= taken_in;
         length_ff    <= length_in;
         seq_ff       <= seq_in;
         frame_buf_ff <= frame_buf_in;
         fill_ff      <= fill_in;
      end
   end

endmodule

/* hw/rtl/isotp_seg_checker.sv */
// Port-level checks for the ISO-TP transmit segmenter, bound to the top level.
// Depends on isotp_tx_segmenter_core_defines.svh and isotp_tx_segmenter_core.
`include "isotp_tx_segmenter_core_defines.svh"

module isotp_seg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);
   import isotp_seg_pkg::*;

   // Hold a stalled response
   `ISOTP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Never stall requests with nothing pending
   `ISOTP_ASSERT_IMP(a_req_open, !rsp_tvalid, req_tready)

   // Single frame: DLC is length plus control byte, and it ends the message
   `ISOTP_ASSERT_IMP(a_single, rsp_tvalid && rsp_tdata[22:19] == PCI_SINGLE,
      rsp_tlast && rsp_tdata[14:11] == rsp_tdata[18:15] + 4'd1)

   // First frame is full and never ends the message
   `ISOTP_ASSERT_IMP(a_first, rsp_tvalid && rsp_tdata[22:19] == PCI_FIRST,
      !rsp_tlast && rsp_tdata[14:11] == CAN_BYTES)

   // DLC stays within a classic CAN frame
   `ISOTP_ASSERT_IMP(a_dlc, rsp_tvalid,
      rsp_tdata[14:11] != 4'd0 && rsp_tdata[14:11] <= CAN_BYTES)

endmodule

bind isotp_tx_segmenter_core isotp_seg_checker u_checker (.*);

/* tb/tb_isotp_tx_segmenter_core.sv */
// Self-checking bench for the ISO-TP transmit segmenter core: streams payload requests,
// predicts every CAN frame and compares each response field by field.
// Depends on isotp_seg_pkg and the isotp_tx_segmenter_core RTL.
module tb_isotp_tx_segmenter_core;
   import isotp_seg_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // Tracks message state and holds the frames still owed by the core
   class segment_ledger;
      logic [10:0] can_id;
      logic [11:0] taken;
      logic [11:0] msg_len;
      logic [3:0]  seq_no;
      logic [3:0]  fill;
      logic [7:0]  frame_bytes [8];
      frame_type   pending_frames [$];
      int          mismatches;
      int          frames_matched;
      int          requests_seen;
      string       byte_names [8] = '{"byte_zero", "byte_one", "byte_two", "byte_three",
                                      "byte_four", "byte_five", "byte_six", "byte_seven"};

      function new();
         can_id = ID_RESET;
         msg_len = '0;
         mismatches = 0;
         frames_matched = 0;
         requests_seen = 0;
         go_idle();
      endfunction

      function void open_frame(logic [3:0] first_slot);
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         fill = first_slot;
      endfunction

      function void go_idle();
         taken = '0;
         seq_no = 4'd1;
         open_frame(4'd0);
      endfunction

      function void set_identifier(logic [10:0] value);
         can_id = value;
      endfunction

      function int pending();
         return pending_frames.size();
      endfunction

      function void queue_frame(logic last);
         frame_type f;
         f.id = can_id;
         f.dlc = fill;
         for (int i = 0; i < 8; i++) f.data[i] = frame_bytes[i];
         f.last = last;
         pending_frames.push_back(f);
      endfunction

      // Advance the segmentation state by one accepted payload request
      function void take_payload_byte(logic [7:0] b, logic [11:0] len);
         logic done;
         requests_seen++;
         if (taken == 0) begin
            // drop a zero-length first byte, stay idle
            if (len == 0) return;
            msg_len = len;
            seq_no = 4'd1;
            open_frame(len <= SF_MAX_LEN ? SLOT_SF : SLOT_FF);
         end
         frame_bytes[fill[2:0]] = b;
         fill = fill + 4'd1;
         taken = taken + 12'd1;
         if (msg_len <= SF_MAX_LEN) begin
            if (taken >= msg_len) begin
               frame_bytes[0] = {PCI_SINGLE, msg_len[3:0]};
               queue_frame(1'b1);
               go_idle();
            end
         end else if (taken == FF_PAYLOAD) begin
            frame_bytes[0] = {PCI_FIRST, msg_len[11:8]};
            frame_bytes[1] = msg_len[7:0];
            queue_frame(1'b0);
            open_frame(SLOT_CF);
         end else if (taken > FF_PAYLOAD && (fill >= CAN_BYTES || taken >= msg_len)) begin
            done = (taken >= msg_len);
            frame_bytes[0] = {PCI_CONSEC, seq_no};
            queue_frame(done);
            seq_no = seq_no + 4'd1;
            if (done) begin
               go_idle();
            end else begin
               open_frame(SLOT_CF);
            end
         end
      endfunction

      task flag_mismatch(string what);
         if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endtask

      // Compare one response frame with the oldest frame owed
      task match_frame(frame_type got);
         frame_type want;
         if (pending_frames.size() == 0) begin
            flag_mismatch($sformatf("frame with no frame owed, id %h dlc %0d", got.id, got.dlc));
         end else begin
            want = pending_frames.pop_front();
            if (got.id !== want.id)
               flag_mismatch($sformatf("frame %0d frame_id got %h want %h",
                                       frames_matched, got.id, want.id));
            if (got.dlc !== want.dlc)
               flag_mismatch($sformatf("frame %0d frame_length got %0d want %0d",
                                       frames_matched, got.dlc, want.dlc));
            for (int i = 0; i < 8; i++)
               if (got.data[i] !== want.data[i])
                  flag_mismatch($sformatf("frame %0d %s got %h want %h", frames_matched,
                                          byte_names[i], got.data[i], want.data[i]));
            if (got.last !== want.last)
               flag_mismatch($sformatf("frame %0d final_frame got %b want %b",
                                       frames_matched, got.last, want.last));
         end
         frames_matched++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   int snd_idle_pct = 21;
   int rcv_idle_pct = 53;

   segment_ledger ledger = new();

   isotp_tx_segmenter_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   // Note accepted requests first, then check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            ledger.take_payload_byte(req_tdata[7:0], req_tdata[19:8]);
         if (rsp_tvalid && rsp_tready)
            ledger.match_frame({rsp_tlast, rsp_tdata[78:0]});
      end
   end

   // End the run when nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_isotp_tx_segmenter_core failed");
      $finish;
   end

   // Present one request, idling first at random, and hold it until accepted
   task automatic send_request(input logic [7:0] b, input logic [11:0] len);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, len, b};
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a whole message; later bytes carry a junk length field
   task automatic send_message(input int len, input logic [7:0] fixed_byte,
                               input bit random_bytes);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = random_bytes ? 8'($urandom_range(255)) : fixed_byte;
         send_request(b, i == 0 ? 12'(len) : 12'($urandom_range(4095)));
      end
   endtask

   // Drop valid and hold until every owed frame has come back
   task automatic wait_for_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Write the identifier once the core is idle
   task automatic write_identifier(input logic [10:0] value);
      wait_for_frames();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_identifier(value);
   endtask

   // Random messages of mostly small sizes, with noise and one pause mid-way
   task automatic run_random_phase(input int item_goal);
      int sent;
      int len;
      int pick;
      bit paused;
      sent = 0;
      paused = 0;
      while (sent < item_goal) begin
         if (!paused && sent >= item_goal / 2) begin
            wait_for_frames();
            paused = 1;
         end
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_request(8'($urandom_range(255)), 12'd0);
         end else begin
            if (pick < 45) len = $urandom_range(1, 7);
            else if (pick < 88) len = $urandom_range(8, 40);
            else len = $urandom_range(100, 230);
            // keep the phase near its request budget
            if (len > item_goal - sent) len = item_goal - sent;
            send_message(len, 8'h00, 1'b1);
            sent += len;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: shortest message, ignored zero length, longest single frame,
      // first frame followed by a full and a partial consecutive frame
      send_message(1, 8'h00, 1'b0);
      send_request(8'hFF, 12'd0);
      send_message(7, 8'hFF, 1'b0);
      send_message(14, 8'h00, 1'b1);

      write_identifier(11'h7FF);
      run_random_phase(70);

      snd_idle_pct = 53;
      rcv_idle_pct = 21;
      write_identifier(11'h000);
      run_random_phase(70);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_identifier(11'($urandom_range(1, 2046)));
      run_random_phase(80);
      // Long message: nonzero length high nibble, two sequence number wraps
      send_message(300, 8'h00, 1'b1);

      wait_for_frames();
      repeat (10) @(posedge clock);
      if (ledger.pending() != 0)
         ledger.flag_mismatch($sformatf("%0d frames never arrived", ledger.pending()));

      $display("Covered %0d payload requests and %0d frames over four identifier values,",
               ledger.requests_seen, ledger.frames_matched);
      $display("single frames up to 7 bytes and segmented messages up to 300 bytes; %0d mismatches.",
               ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("tb_isotp_tx_segmenter_core passed");
      end else begin
         $display("tb_isotp_tx_segmenter_core failed");
      end
      $finish;
   end

endmodule
